FILE: rtl/core/tecs_pkg.sv
// Shared types and constants of the touch event coordinate scaler.
// Used by tecs_axis_scale, touch_event_coordinate_scaler, touch_scale_checker and the testbench; no dependencies.
package tecs_pkg;

	localparam int DefScreenWidth  = 800;
	localparam int DefScreenHeight = 480;
	localparam int MaxCoordW       = 12;

	localparam logic [15:0] EvtSyn    = 16'd0;
	localparam logic [15:0] EvtAbs    = 16'd3;
	localparam logic [15:0] CodeReport = 16'd0;
	localparam logic [15:0] CodeStX   = 16'd0;
	localparam logic [15:0] CodeStY   = 16'd1;
	localparam logic [15:0] CodeMtX   = 16'd53;
	localparam logic [15:0] CodeMtY   = 16'd54;

	localparam logic [31:0] ResetRawMax = 32'd65535;

	typedef enum logic [2:0] {
		CFG_TOUCH_MODE = 3'd0,
		CFG_RAW_MIN_X  = 3'd1,
		CFG_RAW_MAX_X  = 3'd2,
		CFG_RAW_MIN_Y  = 3'd3,
		CFG_RAW_MAX_Y  = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [15:0]        event_type;
		logic [15:0]        event_code;
		logic signed [31:0] event_value;
	} in_item_t;

	typedef struct packed {
		logic [9:0] screen_x;
		logic [8:0] screen_y;
		logic       clipped;
		logic       range_error;
	} out_item_t;

	typedef struct packed {
		logic                 done;
		logic [MaxCoordW-1:0] coord;
		logic                 clip;
	} scl_res_t;

endpackage

FILE: rtl/core/tecs_axis_scale.sv
// Shared axis scaler: (raw - lo) * size_m1 / (hi - lo), saturated to 0..size_m1.
// One quotient bit per cycle by restoring division. Depends on tecs_pkg.
module tecs_axis_scale import tecs_pkg::*; #(
	parameter int QW = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [31:0]    raw,
	input  logic signed [31:0]    lo,
	input  logic signed [31:0]    hi,
	input  logic [QW-1:0]         size_m1,
	output scl_res_t              res
);

	localparam int PW = 32 + QW;
	localparam int CW = (QW > 1) ? $clog2(QW) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_ABS, S_MUL, S_CHK, S_DIV, S_FIN
	} state_t;

	state_t              state_q;
	logic signed [32:0]  num_q;
	logic signed [32:0]  den_q;
	logic [31:0]         num_mag_q;
	logic [31:0]         den_mag_q;
	logic                neg_q;
	logic [PW-1:0]       prod_q;
	logic [31:0]         rem_q;
	logic [QW-1:0]       low_q;
	logic [QW-1:0]       quo_q;
	logic                ovf_q;
	logic [CW-1:0]       cnt_q;
	scl_res_t            res_q;

	logic signed [32:0]  num_neg;
	logic signed [32:0]  den_neg;
	logic [32:0]         trial;
	logic                take;
	logic [32:0]         trial_sub;
	logic                mag_nz;
	logic                too_big;

	assign num_neg   = -num_q;
	assign den_neg   = -den_q;
	assign trial     = {rem_q, low_q[QW-1]};
	assign take      = trial >= {1'b0, den_mag_q};
	assign trial_sub = trial - {1'b0, den_mag_q};
	assign mag_nz    = ovf_q || (quo_q != '0);
	assign too_big   = ovf_q || (quo_q > size_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			res_q.done <= 1'b0;
		end else begin
			res_q.done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						num_q   <= 33'(raw) - 33'(lo);
						den_q   <= 33'(hi) - 33'(lo);
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					num_mag_q <= num_q[32] ? num_neg[31:0] : num_q[31:0];
					den_mag_q <= den_q[32] ? den_neg[31:0] : den_q[31:0];
					neg_q     <= num_q[32] ^ den_q[32];
					state_q   <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PW'(num_mag_q) * PW'(size_m1);
					state_q <= S_CHK;
				end
				S_CHK: begin
					rem_q <= prod_q[PW-1:QW];
					low_q <= prod_q[QW-1:0];
					quo_q <= '0;
					ovf_q <= prod_q[PW-1:QW] >= den_mag_q;
					cnt_q <= CW'(QW - 1);
					state_q <= (prod_q[PW-1:QW] >= den_mag_q) ? S_FIN : S_DIV;
				end
				S_DIV: begin
					rem_q <= take ? trial_sub[31:0] : trial[31:0];
					quo_q <= (quo_q << 1) | QW'(take);
					low_q <= low_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q.done <= 1'b1;
					if (!mag_nz) begin
						res_q.coord <= '0;
						res_q.clip  <= 1'b0;
					end else if (neg_q) begin
						res_q.coord <= '0;
						res_q.clip  <= 1'b1;
					end else if (too_big) begin
						res_q.coord <= MaxCoordW'(size_m1);
						res_q.clip  <= 1'b1;
					end else begin
						res_q.coord <= MaxCoordW'(quo_q);
						res_q.clip  <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res = res_q;

endmodule

FILE: rtl/core/touch_event_coordinate_scaler.sv
// Top level of the touch event coordinate scaler.
// Depends on tecs_pkg and tecs_axis_scale.
//
// Takes touch events (type, code, value) one item at a time and latches the raw X and Y
// of the axis codes that touch_mode selects; a negative value leaves that axis unset.
// An axis event or an ignored event is taken without a stall. A sync report with both
// axes set scales X, then Y, through one shared multiply-and-divide unit that yields one
// quotient bit per cycle. A report with a zero raw range skips the unit and answers with
// range_error set and zero coordinates. in_stall is high while a report is in work; a
// finished item waits in the output register so the next event can be taken at once.
// Configuration writes are always accepted and must be made while the block is idle.
module touch_event_coordinate_scaler import tecs_pkg::*; #(
	parameter int SCREEN_WIDTH  = DefScreenWidth,
	parameter int SCREEN_HEIGHT = DefScreenHeight
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SizeMax = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int QW      = $clog2(SizeMax);
	localparam int XW      = 10;
	localparam int YW      = 9;
	localparam logic [QW-1:0] WidthM1  = QW'(SCREEN_WIDTH - 1);
	localparam logic [QW-1:0] HeightM1 = QW'(SCREEN_HEIGHT - 1);

	typedef enum logic [1:0] {
		ST_IDLE, ST_X, ST_Y, ST_OUT
	} state_t;

	state_t              state_q;
	logic [1:0]          touch_mode_q;
	logic signed [31:0]  raw_min_x_q;
	logic signed [31:0]  raw_max_x_q;
	logic signed [31:0]  raw_min_y_q;
	logic signed [31:0]  raw_max_y_q;
	logic signed [31:0]  latched_x_q;
	logic signed [31:0]  latched_y_q;
	logic                x_present_q;
	logic                y_present_q;
	logic                start_q;
	logic                axis_y_q;
	logic [QW-1:0]       sx_q;
	logic [QW-1:0]       sy_q;
	logic                clip_q;
	logic                rerr_q;
	logic                out_valid_q;
	out_item_t           out_item_q;

	logic                in_acc;
	logic                out_free;
	logic [15:0]         code_x;
	logic [15:0]         code_y;
	logic                is_report;
	logic                range_zero;
	logic [QW+XW-1:0]    sx_ext;
	logic [QW+YW-1:0]    sy_ext;
	scl_res_t            scl_res;

	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign code_x    = touch_mode_q[1] ? CodeMtX : CodeStX;
	assign code_y    = touch_mode_q[1] ? CodeMtY : CodeStY;
	assign is_report = (in_item.event_type == EvtSyn) && (in_item.event_code == CodeReport);
	assign range_zero = (raw_max_x_q == raw_min_x_q) || (raw_max_y_q == raw_min_y_q);
	assign sx_ext    = (QW+XW)'(sx_q);
	assign sy_ext    = (QW+YW)'(sy_q);

	tecs_axis_scale #(
		.QW(QW)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.raw     (axis_y_q ? latched_y_q : latched_x_q),
		.lo      (axis_y_q ? raw_min_y_q : raw_min_x_q),
		.hi      (axis_y_q ? raw_max_y_q : raw_max_x_q),
		.size_m1 (axis_y_q ? HeightM1 : WidthM1),
		.res     (scl_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_mode_q <= 2'd0;
			raw_min_x_q  <= '0;
			raw_max_x_q  <= ResetRawMax;
			raw_min_y_q  <= '0;
			raw_max_y_q  <= ResetRawMax;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TOUCH_MODE: touch_mode_q <= cfg_data[1:0];
				CFG_RAW_MIN_X:  raw_min_x_q  <= cfg_data;
				CFG_RAW_MAX_X:  raw_max_x_q  <= cfg_data;
				CFG_RAW_MIN_Y:  raw_min_y_q  <= cfg_data;
				CFG_RAW_MAX_Y:  raw_max_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			latched_x_q <= '0;
			latched_y_q <= '0;
			x_present_q <= 1'b0;
			y_present_q <= 1'b0;
			start_q     <= 1'b0;
			axis_y_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && touch_mode_q != 2'd0) begin
						if (in_item.event_type == EvtAbs) begin
							if (in_item.event_code == code_x) begin
								latched_x_q <= in_item.event_value;
								x_present_q <= !in_item.event_value[31];
							end else if (in_item.event_code == code_y) begin
								latched_y_q <= in_item.event_value;
								y_present_q <= !in_item.event_value[31];
							end
						end else if (is_report && x_present_q && y_present_q) begin
							x_present_q <= 1'b0;
							y_present_q <= 1'b0;
							clip_q      <= 1'b0;
							rerr_q      <= range_zero;
							sx_q        <= '0;
							sy_q        <= '0;
							if (range_zero) begin
								state_q <= ST_OUT;
							end else begin
								axis_y_q <= 1'b0;
								start_q  <= 1'b1;
								state_q  <= ST_X;
							end
						end
					end
				end
				ST_X: begin
					if (scl_res.done) begin
						sx_q     <= scl_res.coord[QW-1:0];
						clip_q   <= scl_res.clip;
						axis_y_q <= 1'b1;
						start_q  <= 1'b1;
						state_q  <= ST_Y;
					end
				end
				ST_Y: begin
					if (scl_res.done) begin
						sy_q    <= scl_res.coord[QW-1:0];
						clip_q  <= clip_q | scl_res.clip;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_item_q.screen_x    <= sx_ext[XW-1:0];
						out_item_q.screen_y    <= sy_ext[YW-1:0];
						out_item_q.clipped     <= clip_q;
						out_item_q.range_error <= rerr_q;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		scl_res.done |-> (state_q == ST_X || state_q == ST_Y))
		else $error("scaler result outside an axis wait");

	a_y_follows_x: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X && scl_res.done) |=> (start_q && axis_y_q && state_q == ST_Y))
		else $error("Y axis not started after X");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_item_q.clipped && out_item_q.range_error))
		else $error("clipped and range_error together");

	a_range_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.range_error) |->
			(out_item_q.screen_x == '0 && out_item_q.screen_y == '0))
		else $error("non-zero coordinates with range_error");

endmodule

FILE: sim/touch_scale_checker.sv
// Scoreboard for the touch event coordinate scaler: follows the register, event and
// result channels, predicts each screen point and compares it field by field.
// Depends on tecs_pkg.
module touch_scale_checker import tecs_pkg::*; #(
	parameter int SCREEN_WIDTH  = DefScreenWidth,
	parameter int SCREEN_HEIGHT = DefScreenHeight
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_item,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          n_points,
	output int          n_clipped,
	output int          n_range
);

	logic [1:0]  mode;
	logic [31:0] min_x, max_x, min_y, max_y;
	logic [31:0] raw_x, raw_y;
	logic        have_x, have_y;
	out_item_t   expected_points[$];

	// {clip, coordinate}
	function automatic logic [12:0] scale_coord(logic [31:0] raw, logic [31:0] lo,
			logic [31:0] hi, int size);
		longint num, den, q, span_px;
		num     = longint'($signed(raw)) - longint'($signed(lo));
		den     = longint'($signed(hi)) - longint'($signed(lo));
		span_px = longint'(size - 1);
		q       = num * span_px / den;
		if (q < 0)
			return {1'b1, 12'd0};
		if (q > span_px)
			return {1'b1, 12'(size - 1)};
		return {1'b0, q[11:0]};
	endfunction

	task automatic apply_event(in_item_t ev);
		logic [15:0] code_x, code_y;
		logic [12:0] sx, sy;
		out_item_t   pt;
		if (~|mode)
			return;
		code_x = mode[1] ? CodeMtX : CodeStX;
		code_y = mode[1] ? CodeMtY : CodeStY;
		if (ev.event_type == EvtAbs) begin
			if (ev.event_code == code_x) begin
				raw_x  = ev.event_value;
				have_x = !ev.event_value[31];
			end else if (ev.event_code == code_y) begin
				raw_y  = ev.event_value;
				have_y = !ev.event_value[31];
			end
			return;
		end
		if (ev.event_type != EvtSyn || ev.event_code != CodeReport || !have_x || !have_y)
			return;
		pt = '0;
		if (max_x == min_x || max_y == min_y) begin
			pt.range_error = 1'b1;
		end else begin
			sx = scale_coord(raw_x, min_x, max_x, SCREEN_WIDTH);
			sy = scale_coord(raw_y, min_y, max_y, SCREEN_HEIGHT);
			pt.screen_x = sx[9:0];
			pt.screen_y = sy[8:0];
			pt.clipped  = sx[12] | sy[12];
		end
		have_x = 1'b0;
		have_y = 1'b0;
		expected_points.push_back(pt);
	endtask

	task automatic report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_point(out_item_t got);
		out_item_t want;
		if (expected_points.size() == 0) begin
			report($sformatf("unexpected point x=%0d y=%0d clipped=%0d range_error=%0d",
				got.screen_x, got.screen_y, got.clipped, got.range_error));
			return;
		end
		want = expected_points.pop_front();
		if (got.screen_x != want.screen_x)
			report($sformatf("screen_x %0d, want %0d", got.screen_x, want.screen_x));
		if (got.screen_y != want.screen_y)
			report($sformatf("screen_y %0d, want %0d", got.screen_y, want.screen_y));
		if (got.clipped != want.clipped)
			report($sformatf("clipped %0d, want %0d", got.clipped, want.clipped));
		if (got.range_error != want.range_error)
			report($sformatf("range_error %0d, want %0d", got.range_error, want.range_error));
		n_points++;
		n_clipped += want.clipped;
		n_range   += want.range_error;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode      = '0;
			min_x     = '0;
			max_x     = ResetRawMax;
			min_y     = '0;
			max_y     = ResetRawMax;
			raw_x     = '0;
			raw_y     = '0;
			have_x    = 1'b0;
			have_y    = 1'b0;
			expected_points.delete();
			errors    = 0;
			pending   = 0;
			n_points  = 0;
			n_clipped = 0;
			n_range   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TOUCH_MODE: mode  = cfg_data[1:0];
					CFG_RAW_MIN_X:  min_x = cfg_data;
					CFG_RAW_MAX_X:  max_x = cfg_data;
					CFG_RAW_MIN_Y:  min_y = cfg_data;
					CFG_RAW_MAX_Y:  max_y = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				apply_event(in_item);
			if (out_valid && !out_stall)
				check_point(out_item);
			pending = expected_points.size();
		end
	end

endmodule

FILE: sim/tb_touch_event_coordinate_scaler.sv
// Testbench top of the touch event coordinate scaler: drives touch event sequences and
// register settings with random idling; touch_scale_checker predicts and compares.
// Depends on tecs_pkg, touch_event_coordinate_scaler and touch_scale_checker.
module tb_touch_event_coordinate_scaler;
	import tecs_pkg::*;

	localparam int CycleLimit   = 400000;
	localparam int SettleCycles = 40;

	localparam logic [1:0] ModeOff    = 2'd0;
	localparam logic [1:0] ModeSingle = 2'd1;
	localparam logic [1:0] ModeMulti  = 2'd2;
	localparam logic [1:0] ModeUndef  = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_TOUCH_MODE;
	logic [31:0] cfg_data  = '0;

	int errors, pending, n_points, n_clipped, n_range;
	int n_events    = 0;
	int n_writes    = 0;
	int cycle_count = 0;
	int gap_pct     = 0;
	int stall_pct   = 0;

	logic [1:0]  cur_mode  = ModeOff;
	logic [31:0] cur_min_x = '0;
	logic [31:0] cur_max_x = ResetRawMax;
	logic [31:0] cur_min_y = '0;
	logic [31:0] cur_max_y = ResetRawMax;

	touch_event_coordinate_scaler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	touch_scale_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.n_points  (n_points),
		.n_clipped (n_clipped),
		.n_range   (n_range)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_event(logic [15:0] kind, logic [15:0] code, logic [31:0] value);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid                <= 1'b1;
		in_item.event_type  <= kind;
		in_item.event_code  <= code;
		in_item.event_value <= value;
		do @(posedge clk); while (in_stall);
		n_events++;
	endtask

	// hold the sender until every point is out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
		@(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] m);
		write_reg(CFG_TOUCH_MODE, {30'($urandom), m});
		cur_mode = m;
	endtask

	task automatic set_ranges(logic [31:0] lx, logic [31:0] hx, logic [31:0] ly,
			logic [31:0] hy);
		write_reg(CFG_RAW_MIN_X, lx);
		write_reg(CFG_RAW_MAX_X, hx);
		write_reg(CFG_RAW_MIN_Y, ly);
		write_reg(CFG_RAW_MAX_Y, hy);
		cur_min_x = lx;
		cur_max_x = hx;
		cur_min_y = ly;
		cur_max_y = hy;
	endtask

	function automatic logic [31:0] pick_raw(logic [31:0] lo, logic [31:0] hi);
		longint a, b, span, pos;
		logic [63:0] r;
		a = longint'($signed(lo));
		b = longint'($signed(hi));
		if (a > b) begin
			span = a;
			a    = b;
			b    = span;
		end
		span = b - a + 1;
		r    = {$urandom, $urandom};
		pos  = a + longint'(r[62:0]) % span;
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return lo;
			2: return hi;
			3: return lo - 32'd1;
			4: return hi + 32'd1;
			5: return 32'h7FFF_FFFF;
			default: return pos[31:0];
		endcase
	endfunction

	task automatic send_axis(bit on_y);
		if (on_y)
			send_event(EvtAbs, cur_mode[1] ? CodeMtY : CodeStY,
				pick_raw(cur_min_y, cur_max_y));
		else
			send_event(EvtAbs, cur_mode[1] ? CodeMtX : CodeStX,
				pick_raw(cur_min_x, cur_max_x));
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_event(16'($urandom), 16'($urandom), $urandom);
			1: send_event(EvtSyn, 16'($urandom_range(1, 65535)), $urandom);
			2: send_event(EvtAbs, cur_mode[1] ? CodeStX : CodeMtX, $urandom);
			default: send_event(EvtAbs, cur_mode[1] ? CodeMtX : CodeStX,
				32'h8000_0000 | $urandom);
		endcase
	endtask

	// one touch: both axes, maybe repeats and noise, usually closed by a report
	task automatic touch_sequence(output int counted);
		bit y_first;
		y_first = $urandom_range(0, 1);
		send_axis(y_first);
		if ($urandom_range(0, 7) == 0)
			send_noise();
		send_axis(!y_first);
		counted = 2;
		repeat ($urandom_range(0, 2)) begin
			send_axis($urandom_range(0, 1));
			counted++;
		end
		if ($urandom_range(0, 9) != 0) begin
			send_event(EvtSyn, CodeReport, $urandom);
			counted++;
		end
	endtask

	initial begin
		int k, phase_items;
		logic [31:0] lo, hi;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct   = 10;
		stall_pct = 5;

		send_event(EvtAbs, CodeStX, 32'd100);
		send_event(EvtAbs, CodeMtY, 32'd100);
		send_event(EvtSyn, CodeReport, 32'd0);
		drain();
		set_mode(ModeSingle);
		send_event(EvtAbs, CodeStX, 32'd0);
		send_event(EvtAbs, CodeStY, 32'd0);
		send_event(EvtSyn, CodeReport, 32'd0);
		send_event(EvtAbs, CodeStX, 32'd65535);
		send_event(EvtAbs, CodeStY, 32'd65535);
		send_event(EvtSyn, CodeReport, 32'd0);
		send_event(EvtAbs, CodeStX, 32'h7FFF_FFFF);
		send_event(EvtAbs, CodeStY, 32'd40000);
		send_event(EvtSyn, CodeReport, 32'd0);
		send_event(EvtAbs, CodeStX, 32'h8000_0000);
		send_event(EvtAbs, CodeStY, 32'd9);
		send_event(EvtSyn, CodeReport, 32'd0);
		send_event(EvtAbs, CodeStX, 32'd300);
		send_event(EvtSyn, 16'hFFFF, 32'd0);
		send_event(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_event(EvtAbs, CodeMtX, 32'd5);
		send_event(EvtSyn, CodeReport, 32'd0);
		drain();
		set_mode(ModeUndef);
		send_event(EvtAbs, CodeMtX, 32'd1000);
		send_event(EvtAbs, CodeMtY, 32'd2000);
		send_event(EvtSyn, CodeReport, 32'd0);
		drain();
		set_ranges(32'd5, 32'd5, 32'd0, ResetRawMax);
		send_event(EvtAbs, CodeMtX, 32'd1);
		send_event(EvtAbs, CodeMtY, 32'd1);
		send_event(EvtSyn, CodeReport, 32'd0);
		drain();

		set_mode(ModeOff);
		set_ranges(32'd0, ResetRawMax, 32'd0, ResetRawMax);
		repeat (30)
			touch_sequence(k);

		for (int ph = 1; ph <= 11; ph++) begin
			drain();
			gap_pct   = (ph >= 10 || ph % 3 == 0) ? 0 : ((ph % 2 != 0) ? 30 : 10);
			stall_pct = (ph >= 10 || ph % 4 == 1) ? 0 : ((ph % 2 != 0) ? 5 : 15);
			case ((ph + 2) % 6)
				0: set_ranges(32'd0, ResetRawMax, 32'd0, ResetRawMax);
				1: set_ranges(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
				2: begin
					lo = $urandom_range(0, 1000);
					hi = lo + $urandom_range(1, 5000);
					set_ranges(hi, lo, hi, lo);
				end
				3: begin
					lo = 32'($urandom_range(0, 2000)) - 32'd1000;
					hi = lo + $urandom_range(1, 3000);
					set_ranges(lo, hi, lo + 32'd7, hi + $urandom_range(0, 900));
				end
				4: set_ranges($urandom, $urandom, $urandom, $urandom);
				default: begin
					lo = $urandom;
					if ($urandom_range(0, 1))
						set_ranges(lo, lo, 32'd0, ResetRawMax);
					else
						set_ranges(32'd0, ResetRawMax, lo, lo);
				end
			endcase
			case (ph)
				1: set_mode(ModeSingle);
				2: set_mode(ModeMulti);
				3: set_mode(ModeUndef);
				default: set_mode(2'($urandom_range(ModeSingle, ModeUndef)));
			endcase
			phase_items = 0;
			while (phase_items < 100) begin
				touch_sequence(k);
				phase_items += k;
			end
		end

		drain();
		$display("%0d events over %0d register writes; %0d points checked,", n_events,
			n_writes, n_points);
		$display("%0d of them clipped and %0d with a zero range", n_clipped, n_range);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: touch_event_coordinate_scaler.f
rtl/core/tecs_pkg.sv
rtl/core/tecs_axis_scale.sv
rtl/core/touch_event_coordinate_scaler.sv
sim/touch_scale_checker.sv
sim/tb_touch_event_coordinate_scaler.sv
